/* design/rlpd_pkg.sv */
// shared types, codes and helpers of the rgb led preset dimmer
`timescale 1ns / 1ps

package rlpd_pkg;

   typedef enum logic [1:0] {
      OP_ACTIVATE  = 2'd0,
      OP_SET_LEVEL = 2'd1,
      OP_ADJUST    = 2'd2,
      OP_OFF       = 2'd3
   } op_type;

   localparam logic [1:0] PRESET_GREEN = 2'd0;
   localparam logic [1:0] PRESET_RED   = 2'd1;
   localparam logic [1:0] PRESET_PINK  = 2'd2;
   localparam logic [1:0] PRESET_BLUE  = 2'd3;

   localparam int NUM_PRESETS = 4;

   localparam logic [7:0] LEVEL_RESET = 8'd255;
   localparam logic signed [2:0] LED_OFF = -3'sd1;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   typedef struct packed {
      op_type            operation;
      logic [1:0]        preset;
      logic [7:0]        level;
      logic signed [8:0] delta;
   } item_type;

   typedef struct packed {
      logic              emit;
      rgb_type           colour;
      logic [7:0]        level;
      logic signed [2:0] active_preset;
   } event_type;

   function automatic rgb_type preset_reset(input logic [1:0] idx);
      rgb_type c;
      case (idx)
         PRESET_GREEN: c = '{red: 8'd0,   green: 8'd255, blue: 8'd0};
         PRESET_RED:   c = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
         PRESET_PINK:  c = '{red: 8'd255, green: 8'd105, blue: 8'd180};
         default:      c = '{red: 8'd0,   green: 8'd0,   blue: 8'd255};
      endcase
      return c;
   endfunction

   // saturating add of a signed change to a channel
   function automatic logic [7:0] sat_add(input logic [7:0] c, input logic signed [8:0] d);
      logic signed [10:0] sum;
      logic [7:0]         res;
      sum = $signed({3'b000, c}) + 11'(d);
      if (sum < 11'sd0) begin
         res = 8'd0;
      end else if (sum > 11'sd255) begin
         res = 8'd255;
      end else begin
         res = sum[7:0];
      end
      return res;
   endfunction

endpackage

/* design/rlpd_state.sv */
// preset store, brightness and lit preset with per-request update logic
`timescale 1ns / 1ps

module rlpd_state (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  rlpd_pkg::item_type  item,
   output rlpd_pkg::event_type evt
);

   rlpd_pkg::rgb_type colours_ff [rlpd_pkg::NUM_PRESETS];
   rlpd_pkg::rgb_type colours_in [rlpd_pkg::NUM_PRESETS];
   logic [7:0]        level_ff, level_in;
   logic              lit_on_ff, lit_on_in;
   logic [1:0]        lit_idx_ff, lit_idx_in;

   rlpd_pkg::rgb_type adjusted;

   always_comb begin
      adjusted = colours_ff[item.preset];
      case (item.preset)
         rlpd_pkg::PRESET_GREEN: begin
            adjusted.green = rlpd_pkg::sat_add(adjusted.green, item.delta);
         end
         rlpd_pkg::PRESET_RED: begin
            adjusted.red = rlpd_pkg::sat_add(adjusted.red, item.delta);
         end
         rlpd_pkg::PRESET_PINK: begin
            adjusted.red  = rlpd_pkg::sat_add(adjusted.red, item.delta);
            adjusted.blue = rlpd_pkg::sat_add(adjusted.blue, item.delta);
         end
         default: begin
            adjusted.blue = rlpd_pkg::sat_add(adjusted.blue, item.delta);
         end
      endcase
   end

   always_comb begin
      colours_in = colours_ff;
      level_in   = level_ff;
      lit_on_in  = lit_on_ff;
      lit_idx_in = lit_idx_ff;
      evt.emit   = 1'b0;
      evt.colour = '0;

      unique case (item.operation)
         rlpd_pkg::OP_ACTIVATE: begin
            evt.emit = 1'b1;
            if (lit_on_ff && lit_idx_ff == item.preset) begin
               lit_on_in = 1'b0;
            end else begin
               lit_on_in  = 1'b1;
               lit_idx_in = item.preset;
               evt.colour = colours_ff[item.preset];
            end
         end
         rlpd_pkg::OP_SET_LEVEL: begin
            if (level_ff != item.level) begin
               level_in   = item.level;
               evt.emit   = lit_on_ff;
               evt.colour = colours_ff[lit_idx_ff];
            end
         end
         rlpd_pkg::OP_ADJUST: begin
            colours_in[item.preset] = adjusted;
            if (lit_on_ff && lit_idx_ff == item.preset) begin
               evt.emit   = 1'b1;
               evt.colour = adjusted;
            end
         end
         rlpd_pkg::OP_OFF: begin
            evt.emit  = 1'b1;
            lit_on_in = 1'b0;
         end
         default: begin
            evt.emit = 1'b0;
         end
      endcase

      evt.level         = level_in;
      evt.active_preset = lit_on_in ? $signed({1'b0, lit_idx_in}) : rlpd_pkg::LED_OFF;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rlpd_pkg::NUM_PRESETS; i++) begin
            colours_ff[i] <= rlpd_pkg::preset_reset(2'(i));
         end
         level_ff   <= rlpd_pkg::LEVEL_RESET;
         lit_on_ff  <= 1'b0;
         lit_idx_ff <= rlpd_pkg::PRESET_GREEN;
      end else if (advance) begin
         colours_ff <= colours_in;
         level_ff   <= level_in;
         lit_on_ff  <= lit_on_in;
         lit_idx_ff <= lit_idx_in;
      end
   end

endmodule

/* design/rlpd_scale.sv */
// brightness scaling of the three channels, floor(channel * level / 255)
`timescale 1ns / 1ps

module rlpd_scale (
   input  rlpd_pkg::rgb_type colour,
   input  logic [7:0]        level,
   output rlpd_pkg::rgb_type duty
);

   // exact divide by 255 for products up to 255 * 255
   function automatic logic [7:0] scale8(input logic [7:0] c, input logic [7:0] l);
      logic [15:0] prod;
      logic [16:0] y;
      logic [16:0] q;
      prod = c * l;
      y    = {1'b0, prod} + 17'd1;
      q    = (y + (y >> 8)) >> 8;
      return q[7:0];
   endfunction

   assign duty.red   = scale8(colour.red, level);
   assign duty.green = scale8(colour.green, level);
   assign duty.blue  = scale8(colour.blue, level);

endmodule

/* design/rgb_led_preset_dimmer.sv */
// top level of the rgb led preset dimmer
`timescale 1ns / 1ps

// Takes one request per cycle on the req_ stream: activate a preset (or turn
// the led off when it is already lit), set the global brightness, adjust a
// preset channel with saturation, or turn the led off. Each request that
// touches the led gives one response on the rsp_ stream with the three duty
// values and the lit preset (-1 when off); other requests give none.
// A request waits in the input register, then the state update and the
// scaling (three 8x8 products and a divide by 255) run combinationally into
// the response register, and one request per cycle is sustained while the
// receiver does not stall. The preset store updates as a request
// leaves the input register, so back to back requests see each other.
// While the receiver stalls, the response holds and the input register
// keeps one more request; req_tready then drops until the response is taken.
// Reset restores the preset colours, brightness 255 and the led off, and
// empties both registers.

module rgb_led_preset_dimmer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // operation [1:0], preset [3:2], level [11:4], delta [20:12], zeros above
   input  logic [rlpd_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // red_duty [7:0], green_duty [15:8], blue_duty [23:16], active_preset [26:24]
   output logic [rlpd_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   logic                stage_valid_ff, stage_valid_in;
   rlpd_pkg::item_type  stage_item_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   rlpd_pkg::rgb_type   duty_ff;
   logic signed [2:0]   active_ff;

   logic                advance;
   rlpd_pkg::item_type  req_item;
   rlpd_pkg::event_type evt;
   rlpd_pkg::rgb_type   duty;

   assign req_item.operation = rlpd_pkg::op_type'(req_tdata[1:0]);
   assign req_item.preset    = req_tdata[3:2];
   assign req_item.level     = req_tdata[11:4];
   assign req_item.delta     = $signed(req_tdata[20:12]);

   assign advance    = stage_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !stage_valid_ff || advance;

   rlpd_state u_state (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (stage_item_ff),
      .evt     (evt)
   );

   rlpd_scale u_scale (
      .colour (evt.colour),
      .level  (evt.level),
      .duty   (duty)
   );

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_tvalid && req_tready) begin
         stage_valid_in = 1'b1;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance && evt.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         stage_item_ff <= req_item;
      end
      if (advance && evt.emit) begin
         duty_ff   <= duty;
         active_ff <= evt.active_preset;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b00000, active_ff, duty_ff.blue, duty_ff.green, duty_ff.red};

   // nothing comes out in the cycle after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("response valid straight after reset");

   // a full input register behind a stalled response blocks new requests
   assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("request taken while pipeline is blocked");

   // the lit preset field is either off or a preset index
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[26] == 1'b0 || rsp_tdata[26:24] == 3'b111))
      else $error("bad lit preset in response");

   // with the led off all duties are zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[26:24] == 3'b111) |-> rsp_tdata[23:0] == 24'd0)
      else $error("non-zero duty while off");

endmodule
